// ----- hw/rtl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the sphere-sphere contact pipeline
// Widths of the coordinate, radius, root and divider datapaths, and the
// sideband records that travel alongside the arithmetic stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

   localparam int COORD_W    = 32;             // center and point width
   localparam int RAD_W      = COORD_W - 1;    // radius width
   localparam int DIFF_W     = COORD_W + 1;    // center difference width
   localparam int SQ_W       = 2 * DIFF_W;     // one squared difference
   localparam int SSUM_W     = SQ_W + 2;       // sum of three squares
   localparam int RSUM_W     = COORD_W;        // radius sum width
   localparam int ROOT_W     = COORD_W;        // distance width
   localparam int RAD2_W     = 2 * ROOT_W;     // radicand seen by the root unit
   localparam int REM_W      = ROOT_W + 3;     // root remainder width
   localparam int NUM_W      = 2 * COORD_W;    // dividend width
   localparam int DEN_W      = COORD_W + 1;    // divisor width
   localparam int QUO_W      = COORD_W;        // quotient width
   localparam int T2_W       = COORD_W + 2;    // ra - rb + len, signed
   localparam int NORM_W     = 32;             // normal component width
   localparam int NORM_SHIFT = 30;             // Q2.30 scale of the normal
   localparam int LANES      = 6;              // three normal and three point lanes
   localparam int LANE_PT    = 3;              // first point lane

   typedef struct packed {
      logic                        hit;
      logic [2:0][COORD_W-1:0]     a;
      logic [2:0]                  dneg;
      logic [2:0][COORD_W-1:0]     dmag;
      logic [RAD_W-1:0]            ra;
      logic [RAD_W-1:0]            rb;
      logic [RSUM_W-1:0]           rsum;
   } ssc_geom_type;

   typedef struct packed {
      logic                        hit;
      logic [2:0][COORD_W-1:0]     a;
      logic [2:0]                  nneg;
      logic [2:0]                  pneg;
      logic                        zn;     // distance is zero
      logic                        zp;     // point divisor is zero
      logic [COORD_W-1:0]          depth;
   } ssc_fin_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ssc_front.sv -----
// ----------------------------------------------------------------------------
// ssc_front: center difference, squared distance and overlap test
// Three stages: difference and radius sum, squares, then the sum of squares
// compared against the squared radius sum.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_front import ssc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic [2:0][COORD_W-1:0] cen_a,
   input  wire logic [2:0][COORD_W-1:0] cen_b,
   input  wire logic [RAD_W-1:0]        rad_a,
   input  wire logic [RAD_W-1:0]        rad_b,
   output logic                         out_valid,
   output ssc_geom_type                 out_geom,
   output logic [RAD2_W-1:0]            out_sq
);

   typedef struct packed {
      logic [2:0][COORD_W-1:0] a;
      logic [2:0]              dneg;
      logic [2:0][DIFF_W-1:0]  dmag;
      logic [RAD_W-1:0]        ra;
      logic [RAD_W-1:0]        rb;
      logic [RSUM_W-1:0]       rsum;
   } st1_type;

   typedef struct packed {
      st1_type                 s1;
      logic [2:0][SQ_W-1:0]    sq;
      logic [2*RSUM_W-1:0]     r2;
   } st2_type;

   logic                       v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   st1_type                    st1_ff, st1_in;
   st2_type                    st2_ff, st2_in;
   ssc_geom_type               geom_ff, geom_in;
   logic [RAD2_W-1:0]          sq_ff, sq_in;
   logic signed [DIFF_W-1:0]   diff [3];
   logic [SSUM_W-1:0]          ssum;

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   always_comb begin
      st1_in.a    = cen_a;
      st1_in.ra   = rad_a;
      st1_in.rb   = rad_b;
      st1_in.rsum = RSUM_W'(rad_a) + RSUM_W'(rad_b);
      for (int k = 0; k < 3; k++) begin
         diff[k] = $signed({cen_b[k][COORD_W-1], cen_b[k]})
                 - $signed({cen_a[k][COORD_W-1], cen_a[k]});
         st1_in.dneg[k] = diff[k][DIFF_W-1];
         st1_in.dmag[k] = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
      end
   end

   always_comb begin
      st2_in.s1 = st1_ff;
      for (int k = 0; k < 3; k++) begin
         st2_in.sq[k] = SQ_W'(st1_ff.dmag[k]) * SQ_W'(st1_ff.dmag[k]);
      end
      st2_in.r2 = (2*RSUM_W)'(st1_ff.rsum) * (2*RSUM_W)'(st1_ff.rsum);
   end

   always_comb begin
      ssum = SSUM_W'(st2_ff.sq[0]) + SSUM_W'(st2_ff.sq[1]) + SSUM_W'(st2_ff.sq[2]);
      geom_in.hit  = ssum <= SSUM_W'(st2_ff.r2);
      geom_in.a    = st2_ff.s1.a;
      geom_in.dneg = st2_ff.s1.dneg;
      for (int k = 0; k < 3; k++) begin
         // A hit bounds every difference by the radius sum, so it fits COORD_W.
         geom_in.dmag[k] = st2_ff.s1.dmag[k][COORD_W-1:0];
      end
      geom_in.ra   = st2_ff.s1.ra;
      geom_in.rb   = st2_ff.s1.rb;
      geom_in.rsum = st2_ff.s1.rsum;
      sq_in        = ssum[RAD2_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff  <= st1_in;
         st2_ff  <= st2_in;
         geom_ff <= geom_in;
         sq_ff   <= sq_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_geom  = geom_ff;
   assign out_sq    = sq_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ssc_sqrt.sv -----
// ----------------------------------------------------------------------------
// ssc_sqrt: pipelined integer square root
// One result bit per stage, digit by digit from the top bit pair of the
// radicand; the geometry record rides along with each word.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_sqrt import ssc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  ssc_geom_type       in_geom,
   input  wire logic [RAD2_W-1:0] in_sq,
   output logic               out_valid,
   output ssc_geom_type       out_geom,
   output logic [ROOT_W-1:0]  out_root
);

   logic                valid_ff [ROOT_W];
   logic                valid_in [ROOT_W];
   logic [REM_W-1:0]    rem_ff   [ROOT_W];
   logic [REM_W-1:0]    rem_in   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_in  [ROOT_W];
   logic [RAD2_W-1:0]   sq_ff    [ROOT_W];
   logic [RAD2_W-1:0]   sq_in    [ROOT_W];
   ssc_geom_type        geom_ff  [ROOT_W];
   ssc_geom_type        geom_in  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int I = ROOT_W - 1 - k;

      logic                prev_valid;
      logic [REM_W-1:0]    prev_rem;
      logic [ROOT_W-1:0]   prev_root;
      logic [RAD2_W-1:0]   prev_sq;
      ssc_geom_type        prev_geom;
      logic [REM_W-1:0]    rem_sh;
      logic [REM_W-1:0]    trial;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_sq    = in_sq;
         assign prev_geom  = in_geom;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_root  = root_ff[k-1];
         assign prev_sq    = sq_ff[k-1];
         assign prev_geom  = geom_ff[k-1];
      end

      always_comb begin
         rem_sh = {prev_rem[REM_W-3:0], prev_sq[2*I+1 -: 2]};
         trial  = REM_W'({prev_root, 2'b01});
         if (rem_sh >= trial) begin
            rem_in[k]  = rem_sh - trial;
            root_in[k] = {prev_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh;
            root_in[k] = {prev_root[ROOT_W-2:0], 1'b0};
         end
         valid_in[k] = prev_valid;
         sq_in[k]    = prev_sq;
         geom_in[k]  = prev_geom;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            sq_ff[k]   <= sq_in[k];
            geom_ff[k] <= geom_in[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_geom  = geom_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/ssc_div.sv -----
// ----------------------------------------------------------------------------
// ssc_div: pipelined restoring divider, six lanes
// One quotient bit per stage for every lane. Each dividend is known to be
// below its divisor times two to the quotient width, so the top half of the
// dividend seeds the remainder directly.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div import ssc_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [LANES-1:0][NUM_W-1:0] in_num,
   input  wire logic [LANES-1:0][DEN_W-1:0] in_den,
   input  ssc_fin_type                      in_fin,
   output logic                             out_valid,
   output logic [LANES-1:0][QUO_W-1:0]      out_quo,
   output ssc_fin_type                      out_fin
);

   logic                          valid_ff [QUO_W];
   logic                          valid_in [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   rem_ff   [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   rem_in   [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff   [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_in   [QUO_W];
   logic [LANES-1:0][NUM_W-1:0]   num_ff   [QUO_W];
   logic [LANES-1:0][NUM_W-1:0]   num_in   [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   den_ff   [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   den_in   [QUO_W];
   ssc_fin_type                   fin_ff   [QUO_W];
   ssc_fin_type                   fin_in   [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int J = QUO_W - 1 - k;

      logic                          prev_valid;
      logic [LANES-1:0][DEN_W-1:0]   prev_rem;
      logic [LANES-1:0][QUO_W-1:0]   prev_quo;
      logic [LANES-1:0][NUM_W-1:0]   prev_num;
      logic [LANES-1:0][DEN_W-1:0]   prev_den;
      ssc_fin_type                   prev_fin;
      logic [DEN_W:0]                rem_sh [LANES];

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_quo   = '0;
         assign prev_num   = in_num;
         assign prev_den   = in_den;
         assign prev_fin   = in_fin;
         for (genvar n = 0; n < LANES; n++) begin : g_seed
            assign prev_rem[n] = DEN_W'(in_num[n][NUM_W-1:QUO_W]);
         end
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_num   = num_ff[k-1];
         assign prev_den   = den_ff[k-1];
         assign prev_fin   = fin_ff[k-1];
      end

      always_comb begin
         for (int n = 0; n < LANES; n++) begin
            rem_sh[n] = {prev_rem[n], prev_num[n][J]};
            if (rem_sh[n] >= {1'b0, prev_den[n]}) begin
               rem_in[k][n] = DEN_W'(rem_sh[n] - {1'b0, prev_den[n]});
               quo_in[k][n] = {prev_quo[n][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[k][n] = rem_sh[n][DEN_W-1:0];
               quo_in[k][n] = {prev_quo[n][QUO_W-2:0], 1'b0};
            end
         end
         valid_in[k] = prev_valid;
         num_in[k]   = prev_num;
         den_in[k]   = prev_den;
         fin_in[k]   = prev_fin;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            num_ff[k] <= num_in[k];
            den_ff[k] <= den_in[k];
            fin_ff[k] <= fin_in[k];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_fin   = fin_ff[QUO_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/sphere_sphere_contact.sv -----
// ----------------------------------------------------------------------------
// sphere_sphere_contact: contact test and contact data for two spheres
// Each req word carries two centers and radii in Q16.16; each rsp word gives
// hit, the contact point, the unit normal from A to B in Q2.30 and the depth.
//
// Channels: req_* in, rsp_* out, both valid/stall. A word is taken at a clock
// edge with valid high and stall low. csr_wr_en writes csr_wr_data into the
// contact policy (0 = divide A to B by the radii, 1 = middle of the overlap);
// write it only while no word is in flight.
// Stages from req acceptance to rsp_valid: three front stages,
// 32 square root stages (one distance bit each), one operand stage, 32
// divider stages (one quotient bit each) and the output register.
// Throughput: one word per cycle; every stage is registered and moves
// together, so the rate is set by nothing but the output handshake.
// Stall: while rsp_valid is high and rsp_stall is high the whole pipeline
// holds and req_stall is raised; nothing is dropped or repeated.
// Reset: clears all valid bits and sets the policy to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_sphere_contact import ssc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COORD_W-1:0]  req_center_a_x,
   input  wire logic [COORD_W-1:0]  req_center_a_y,
   input  wire logic [COORD_W-1:0]  req_center_a_z,
   input  wire logic [RAD_W-1:0]    req_radius_a,
   input  wire logic [COORD_W-1:0]  req_center_b_x,
   input  wire logic [COORD_W-1:0]  req_center_b_y,
   input  wire logic [COORD_W-1:0]  req_center_b_z,
   input  wire logic [RAD_W-1:0]    req_radius_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_hit,
   output logic [COORD_W-1:0]       rsp_point_x,
   output logic [COORD_W-1:0]       rsp_point_y,
   output logic [COORD_W-1:0]       rsp_point_z,
   output logic [NORM_W-1:0]        rsp_normal_x,
   output logic [NORM_W-1:0]        rsp_normal_y,
   output logic [NORM_W-1:0]        rsp_normal_z,
   output logic [COORD_W-1:0]       rsp_depth,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_wr_data
);

   logic                          advance;
   logic                          policy_ff, policy_in;

   logic                          front_valid;
   ssc_geom_type                  front_geom;
   logic [RAD2_W-1:0]             front_sq;

   logic                          sqrt_valid;
   ssc_geom_type                  sqrt_geom;
   logic [ROOT_W-1:0]             sqrt_root;

   logic                          prep_valid_ff, prep_valid_in;
   logic [LANES-1:0][NUM_W-1:0]   prep_num_ff, prep_num_in;
   logic [LANES-1:0][DEN_W-1:0]   prep_den_ff, prep_den_in;
   ssc_fin_type                   prep_fin_ff, prep_fin_in;

   logic                          div_valid;
   logic [LANES-1:0][QUO_W-1:0]   div_quo;
   ssc_fin_type                   div_fin;

   logic signed [T2_W-1:0]        t2;
   logic                          t2neg;
   logic [COORD_W-1:0]            t2mag;
   logic [COORD_W-1:0]            mul_b;
   logic [DEN_W-1:0]              den_pt;
   logic                          zp;

   logic [NORM_W-1:0]             nq [3];
   logic signed [COORD_W+1:0]     pq [3];
   logic signed [COORD_W+1:0]     psum [3];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [COORD_W-1:0]            rsp_point_ff [3];
   logic [COORD_W-1:0]            rsp_point_in [3];
   logic [NORM_W-1:0]             rsp_normal_ff [3];
   logic [NORM_W-1:0]             rsp_normal_in [3];
   logic [COORD_W-1:0]            rsp_depth_ff, rsp_depth_in;

   // The pipeline moves as one unless a finished word is waiting on the output.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign policy_in = csr_wr_en ? csr_wr_data : policy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
      end else begin
         policy_ff <= policy_in;
      end
   end

   ssc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .cen_a     ({req_center_a_z, req_center_a_y, req_center_a_x}),
      .cen_b     ({req_center_b_z, req_center_b_y, req_center_b_x}),
      .rad_a     (req_radius_a),
      .rad_b     (req_radius_b),
      .out_valid (front_valid),
      .out_geom  (front_geom),
      .out_sq    (front_sq)
   );

   ssc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_geom   (front_geom),
      .in_sq     (front_sq),
      .out_valid (sqrt_valid),
      .out_geom  (sqrt_geom),
      .out_root  (sqrt_root)
   );

   // Operand stage: numerators, divisors and the guards for each lane.
   always_comb begin
      t2 = $signed({3'b000, sqrt_geom.ra}) - $signed({3'b000, sqrt_geom.rb})
         + $signed({2'b00, sqrt_root});
      t2neg = t2[T2_W-1];
      t2mag = t2neg ? COORD_W'(-t2) : COORD_W'(t2);
      mul_b = policy_ff ? t2mag : COORD_W'(sqrt_geom.ra);
      den_pt = policy_ff ? {sqrt_root, 1'b0} : DEN_W'(sqrt_geom.rsum);
      zp = policy_ff ? (sqrt_root == '0) : (sqrt_geom.rsum == '0);
      for (int k = 0; k < 3; k++) begin
         prep_num_in[k]         = NUM_W'(sqrt_geom.dmag[k]) << NORM_SHIFT;
         prep_den_in[k]         = DEN_W'(sqrt_root);
         prep_num_in[LANE_PT+k] = NUM_W'(sqrt_geom.dmag[k]) * NUM_W'(mul_b);
         prep_den_in[LANE_PT+k] = den_pt;
      end
      prep_fin_in.hit   = sqrt_geom.hit;
      prep_fin_in.a     = sqrt_geom.a;
      prep_fin_in.nneg  = sqrt_geom.dneg;
      prep_fin_in.pneg  = sqrt_geom.dneg ^ {3{policy_ff & t2neg}};
      prep_fin_in.zn    = sqrt_root == '0;
      prep_fin_in.zp    = zp;
      prep_fin_in.depth = sqrt_geom.rsum - sqrt_root;
      prep_valid_in     = sqrt_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= prep_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_num_ff <= prep_num_in;
         prep_den_ff <= prep_den_in;
         prep_fin_ff <= prep_fin_in;
      end
   end

   ssc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prep_valid_ff),
      .in_num    (prep_num_ff),
      .in_den    (prep_den_ff),
      .in_fin    (prep_fin_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_fin   (div_fin)
   );

   // Signs, offset from center A, saturation and the special cases.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nq[k]   = NORM_W'(div_quo[k]);
         pq[k]   = $signed({2'b00, div_quo[LANE_PT+k]});
         psum[k] = $signed({{2{div_fin.a[k][COORD_W-1]}}, div_fin.a[k]})
                 + (div_fin.pneg[k] ? -pq[k] : pq[k]);
         rsp_normal_in[k] = div_fin.zn ? '0 : (div_fin.nneg[k] ? -nq[k] : nq[k]);
         if (div_fin.zp) begin
            rsp_point_in[k] = div_fin.a[k];
         end else if (psum[k][COORD_W+1:COORD_W-1] == 3'b000
                   || psum[k][COORD_W+1:COORD_W-1] == 3'b111) begin
            rsp_point_in[k] = psum[k][COORD_W-1:0];
         end else if (psum[k][COORD_W+1]) begin
            rsp_point_in[k] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            rsp_point_in[k] = {1'b0, {(COORD_W-1){1'b1}}};
         end
         if (!div_fin.hit) begin
            rsp_normal_in[k] = '0;
            rsp_point_in[k]  = '0;
         end
      end
      rsp_hit_in   = div_fin.hit;
      rsp_depth_in = div_fin.hit ? div_fin.depth : '0;
      rsp_valid_in = div_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_point_ff  <= rsp_point_in;
         rsp_normal_ff <= rsp_normal_in;
         rsp_depth_ff  <= rsp_depth_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_point_x  = rsp_point_ff[0];
   assign rsp_point_y  = rsp_point_ff[1];
   assign rsp_point_z  = rsp_point_ff[2];
   assign rsp_normal_x = rsp_normal_ff[0];
   assign rsp_normal_y = rsp_normal_ff[1];
   assign rsp_normal_z = rsp_normal_ff[2];
   assign rsp_depth    = rsp_depth_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ssc_checker.sv -----
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks for sphere_sphere_contact
// Watches the channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_checker import ssc_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic                rsp_hit,
   input wire logic [COORD_W-1:0]  rsp_point_x,
   input wire logic [COORD_W-1:0]  rsp_point_y,
   input wire logic [COORD_W-1:0]  rsp_point_z,
   input wire logic [NORM_W-1:0]   rsp_normal_x,
   input wire logic [NORM_W-1:0]   rsp_normal_y,
   input wire logic [NORM_W-1:0]   rsp_normal_z,
   input wire logic [COORD_W-1:0]  rsp_depth
);

   localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1) << NORM_SHIFT;

   // A waiting word stays valid, and its hit, x point, x normal and depth hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_point_x) && $stable(rsp_normal_x) && $stable(rsp_depth))
      else $error("rsp word changed while stalled");

   // Input is held back exactly when a finished word waits on the output.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow the output stall");

   // A miss reports nothing but the miss itself.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_point_x == '0 && rsp_point_y == '0
         && rsp_point_z == '0 && rsp_normal_x == '0 && rsp_normal_y == '0
         && rsp_normal_z == '0 && rsp_depth == '0)
      else $error("miss word carries nonzero fields");

   // Normal components never exceed unit length.
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> $signed(rsp_normal_x) <= NORM_ONE
         && $signed(rsp_normal_x) >= -NORM_ONE
         && $signed(rsp_normal_y) <= NORM_ONE && $signed(rsp_normal_y) >= -NORM_ONE
         && $signed(rsp_normal_z) <= NORM_ONE && $signed(rsp_normal_z) >= -NORM_ONE)
      else $error("normal component out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (.*);

`default_nettype wire
